// File: src/kinetic_indexed_min_heap_core_defines.svh
// assertion macros for the kinetic heap checker
`ifndef KINETIC_INDEXED_MIN_HEAP_CORE_DEFINES_SVH
`define KINETIC_INDEXED_MIN_HEAP_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define KH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication checked outside reset
`define KH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

// File: src/kih_pkg.sv
package kih_pkg;
    localparam int CAPACITY_DEF = 1024;
    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_ID  = 2'd2;
    localparam logic [31:0] NO_EVENT  = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] intercept;
        logic signed [31:0] slope;
        logic [9:0]         item_id;
        logic signed [31:0] new_time;
    } kih_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               event_found;
        logic signed [31:0] event_time;
        logic [10:0]        entry_count;
        logic [9:0]         min_id;
    } kih_out_t;

    // controller to datapath
    typedef struct packed {
        logic       load_in;      // capture input beat
        logic       append;       // write new entry at count+1
        logic       rd_a;         // read slot a into reg a
        logic       rd_b;         // read slot b into reg b
        logic       swap;         // write a<-b and b<-a
        logic       key_a;        // form key of a (stage 1)
        logic       key_b;        // form key of b (stage 1)
        logic       key_fin;      // finish keys (stage 2)
        logic       div_start;    // start crossing division
        logic       pair_done;    // fold quotient into best
        logic       clr_best;
        logic       set_time;
        logic       root_rd;      // read slot 1 id
        logic       out_load;
    } kih_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic a_lt_b;       // key_b < key_a
        logic slope_eq;
        logic div_busy;
    } kih_stat_t;
endpackage

// File: src/kih_div.sv
module kih_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [48:0]  num,
    input  logic signed [32:0]  den,
    output logic                busy,
    output logic signed [48:0]  quo
);
    // restoring divider on magnitudes, one quotient bit a cycle
    logic [48:0] rem_reg, rem_next;
    logic [48:0] q_reg, q_next;
    logic [32:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [49:0] trial;
    logic [49:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, q_reg[48]};
        trial     = shifted - {17'd0, d_reg};
        if (start)
        begin
            rem_next  = '0;
            q_next    = num[48] ? 49'(-num) : num;
            d_next    = den[32] ? 33'(-den) : den;
            neg_next  = num[48] ^ den[32];
            cnt_next  = 6'd49;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[47:0], ~trial[49]};
            rem_next = trial[49] ? shifted[48:0] : trial[48:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quo  = neg_reg ? 49'(-q_reg) : q_reg;
endmodule

// File: src/kih_datapath.sv
module kih_datapath #(
    parameter int CAPACITY = kih_pkg::CAPACITY_DEF,
    parameter int SW = $clog2(CAPACITY + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kih_pkg::kih_in_t  in_item,
    input  kih_pkg::kih_cmd_t cmd,
    input  logic [SW-1:0]     addr_a,
    input  logic [SW-1:0]     addr_b,
    input  logic [SW-1:0]     count,
    input  logic [1:0]        status_in,
    output kih_pkg::kih_stat_t stat,
    output kih_pkg::kih_out_t out_item,
    output kih_pkg::kih_in_t  held
);
    import kih_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    // entry store, index by slot-1
    logic signed [31:0] mem_ic [CAPACITY];
    logic signed [31:0] mem_sl [CAPACITY];
    logic [9:0]         mem_id [CAPACITY];
    // position map from item id to slot; written but never read
    logic [SW-1:0]      pos_map [CAPACITY];

    kih_in_t            in_reg;
    logic signed [31:0] now_reg;
    logic signed [31:0] ic_a_reg, sl_a_reg, ic_b_reg, sl_b_reg;
    logic [9:0]         id_a_reg, id_b_reg, root_reg;
    logic signed [63:0] pa_reg, pb_reg, ka_reg, kb_reg;
    logic               have_reg;
    logic signed [48:0] best_reg;
    kih_out_t           out_reg;
    logic signed [48:0] quo;
    logic               div_busy;
    logic signed [48:0] num;
    logic signed [32:0] den;
    logic [AW-1:0]      ia, ib, ic;

    assign ia = AW'(addr_a - SW'(1));
    assign ib = AW'(addr_b - SW'(1));
    assign ic = AW'(count);

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem_ic[ic] <= in_reg.intercept;
            mem_sl[ic] <= in_reg.slope;
            mem_id[ic] <= in_reg.item_id;
            pos_map[AW'(in_reg.item_id)] <= count + SW'(1);
        end
        else if (cmd.swap)
        begin
            mem_ic[ia] <= ic_b_reg;
            mem_sl[ia] <= sl_b_reg;
            mem_id[ia] <= id_b_reg;
            mem_ic[ib] <= ic_a_reg;
            mem_sl[ib] <= sl_a_reg;
            mem_id[ib] <= id_a_reg;
            pos_map[AW'(id_b_reg)] <= addr_a;
            pos_map[AW'(id_a_reg)] <= addr_b;
        end
        if (cmd.rd_a)
        begin
            ic_a_reg <= mem_ic[ia];
            sl_a_reg <= mem_sl[ia];
            id_a_reg <= mem_id[ia];
        end
        if (cmd.rd_b)
        begin
            ic_b_reg <= mem_ic[ib];
            sl_b_reg <= mem_sl[ib];
            id_b_reg <= mem_id[ib];
        end
        if (cmd.root_rd)
            root_reg <= mem_id[0];
    end

    // key: intercept*2^16 + slope*now, 32x32 product then sum
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_item;
        if (cmd.key_a)
            pa_reg <= sl_a_reg * now_reg;
        if (cmd.key_b)
            pb_reg <= sl_b_reg * now_reg;
        if (cmd.key_fin)
        begin
            ka_reg <= pa_reg + (64'(ic_a_reg) <<< 16);
            kb_reg <= pb_reg + (64'(ic_b_reg) <<< 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            now_reg <= '0;
        else if (cmd.set_time)
            now_reg <= in_reg.new_time;
    end

    // crossing time of parent a and child b
    assign num = (49'(ic_b_reg) - 49'(ic_a_reg)) <<< 16;
    assign den = 33'(sl_a_reg) - 33'(sl_b_reg);

    kih_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den),
        .busy  (div_busy),
        .quo   (quo)
    );

    // earliest future crossing, cleared for every new beat
    always_ff @(posedge clk)
    begin
        if (cmd.clr_best || cmd.load_in)
            have_reg <= 1'b0;
        else if (cmd.pair_done && quo > 49'(now_reg) && (!have_reg || quo < best_reg))
        begin
            have_reg <= 1'b1;
            best_reg <= quo;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status      <= status_in;
            out_reg.event_found <= have_reg;
            out_reg.entry_count <= 11'(count);
            out_reg.min_id      <= (count != '0) ? root_reg : 10'd0;
            if (!have_reg)
                out_reg.event_time <= NO_EVENT;
            else if (best_reg > 49'sh0_7FFF_FFFF)
                out_reg.event_time <= 32'h7FFF_FFFF;
            else if (best_reg < -49'sh0_8000_0000)
                out_reg.event_time <= 32'h8000_0000;
            else
                out_reg.event_time <= best_reg[31:0];
        end
    end

    assign stat.a_lt_b   = kb_reg < ka_reg;
    assign stat.slope_eq = (sl_a_reg == sl_b_reg);
    assign stat.div_busy = div_busy;
    assign out_item = out_reg;
    assign held = in_reg;
endmodule

// File: src/kih_ctrl.sv
module kih_ctrl #(
    parameter int CAPACITY = kih_pkg::CAPACITY_DEF,
    parameter int SW = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  kih_pkg::kih_in_t   held,
    input  kih_pkg::kih_stat_t stat,
    output kih_pkg::kih_cmd_t  cmd,
    output logic [SW-1:0]      addr_a,
    output logic [SW-1:0]      addr_b,
    output logic [SW-1:0]      count,
    output logic [1:0]         status
);
    import kih_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RD = 4'd2, S_K1 = 4'd3,
        S_K2 = 4'd4, S_CMP = 4'd5, S_SWAP = 4'd6, S_DIV = 4'd7, S_DIVW = 4'd8,
        S_FOLD = 4'd9, S_ROOT = 4'd10, S_OUT = 4'd11, S_HOLD = 4'd12,
        S_RDC = 4'd13, S_K1C = 4'd14, S_WAIT = 4'd15;

    localparam logic [1:0] M_UP = 2'd0, M_DOWN = 2'd1, M_SCAN = 2'd2;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] a_reg, a_next, b_reg, b_next;
    logic [SW-1:0] best_reg, best_next;   // slot currently being sifted down
    logic [SW-1:0] root_reg, root_next;   // sift-down start slot
    logic [1:0]    st_reg, st_next;
    logic          ch_reg, ch_next;       // second child under test
    logic [SW:0]   lc;

    // left child of the current sift-down slot
    assign lc = {best_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        best_next  = best_reg;
        root_next  = root_reg;
        st_next    = st_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next = ST_OK;
                case (held.func)
                    FUNC_INSERT:
                    begin
                        if (32'(cnt_reg) >= CAPACITY)
                        begin
                            st_next = ST_FULL;
                            state_next = S_ROOT;
                        end
                        else if (32'(held.item_id) >= CAPACITY)
                        begin
                            st_next = ST_BAD_ID;
                            state_next = S_ROOT;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            cnt_next   = cnt_reg + SW'(1);
                            mode_next  = M_UP;
                            b_next     = cnt_reg + SW'(1);
                            a_next     = SW'((cnt_reg + SW'(1)) >> 1);
                            state_next = (cnt_reg == '0) ? S_ROOT : S_RD;
                        end
                    end
                    FUNC_ADVANCE:
                    begin
                        cmd.set_time = 1'b1;
                        mode_next  = M_DOWN;
                        ch_next    = 1'b0;
                        root_next  = cnt_reg >> 1;
                        best_next  = cnt_reg >> 1;
                        state_next = S_ROOT;
                        if ((cnt_reg >> 1) != '0)
                        begin
                            a_next = cnt_reg >> 1;
                            state_next = S_RDC;
                        end
                    end
                    FUNC_QUERY:
                    begin
                        cmd.clr_best = 1'b1;
                        mode_next  = M_SCAN;
                        a_next     = SW'(1);
                        ch_next    = 1'b0;
                        b_next     = SW'(2);
                        state_next = (cnt_reg >= SW'(2)) ? S_RD : S_ROOT;
                    end
                    default: state_next = S_ROOT;
                endcase
            end
            // sift-down: pick next child of best_reg to compare
            S_RDC:
            begin
                if (!ch_reg)
                begin
                    if (lc > {1'b0, cnt_reg})
                        state_next = S_SWAP;
                    else
                    begin
                        b_next = lc[SW-1:0];
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (lc + 1 > {1'b0, cnt_reg})
                        state_next = S_SWAP;
                    else
                    begin
                        b_next = SW'(lc + 1);
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_a = 1'b1;
                cmd.rd_b = 1'b1;
                state_next = (mode_reg == M_SCAN) ? S_DIV : S_K1;
            end
            S_K1:
            begin
                cmd.key_a = 1'b1;
                cmd.key_b = 1'b1;
                state_next = S_K2;
            end
            S_K2:
            begin
                cmd.key_fin = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (mode_reg == M_UP)
                begin
                    // a parent, b child
                    if (stat.a_lt_b)
                    begin
                        cmd.swap = 1'b1;
                        b_next = a_reg;
                        a_next = a_reg >> 1;
                        state_next = (a_reg == SW'(1)) ? S_ROOT : S_RD;
                    end
                    else
                        state_next = S_ROOT;
                end
                else
                begin
                    // a is best so far, b is a child
                    if (stat.a_lt_b)
                        a_next = b_reg;
                    state_next = S_K1C;
                end
            end
            S_K1C:
            begin
                if (!ch_reg)
                begin
                    ch_next = 1'b1;
                    state_next = S_RDC;
                end
                else
                begin
                    ch_next = 1'b0;
                    state_next = S_SWAP;
                end
            end
            // sift-down: exchange best_reg with a_reg, or move to next root
            S_SWAP:
            begin
                ch_next = 1'b0;
                if (a_reg != best_reg)
                begin
                    b_next = best_reg;
                    state_next = S_HOLD;
                end
                else if (root_reg == SW'(1))
                    state_next = S_ROOT;
                else
                begin
                    root_next = root_reg - SW'(1);
                    best_next = root_reg - SW'(1);
                    a_next = root_reg - SW'(1);
                    state_next = S_RDC;
                end
            end
            S_HOLD:
            begin
                // reread both rows so swap uses fresh data
                cmd.rd_a = 1'b1;
                cmd.rd_b = 1'b1;
                state_next = S_OUT;
                st_next = st_reg;
                mode_next = M_DOWN;
                best_next = best_reg;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (mode_reg == M_SCAN)
                begin
                    cmd.pair_done = 1'b1;
                    if (!ch_reg && (b_reg + SW'(1)) <= cnt_reg)
                    begin
                        ch_next = 1'b1;
                        b_next = b_reg + SW'(1);
                        state_next = S_RD;
                    end
                    else if ({1'b0, a_reg + SW'(1), 1'b0} <= {1'b0, cnt_reg})
                    begin
                        ch_next = 1'b0;
                        a_next = a_reg + SW'(1);
                        b_next = SW'({a_reg + SW'(1), 1'b0});
                        state_next = S_RD;
                    end
                    else
                        state_next = S_ROOT;
                end
                else
                begin
                    cmd.swap = 1'b1;
                    best_next = a_reg;
                    state_next = S_RDC;
                end
            end
            S_DIV:
            begin
                if (stat.slope_eq)
                begin
                    // equal slopes: no division, the wait state skips the pair
                    state_next = S_DIVW;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (!stat.div_busy)
                begin
                    if (stat.slope_eq)
                    begin
                        // skip pair: advance without folding
                        if (!ch_reg && (b_reg + SW'(1)) <= cnt_reg)
                        begin
                            ch_next = 1'b1;
                            b_next = b_reg + SW'(1);
                            state_next = S_RD;
                        end
                        else if ({1'b0, a_reg + SW'(1), 1'b0} <= {1'b0, cnt_reg})
                        begin
                            ch_next = 1'b0;
                            a_next = a_reg + SW'(1);
                            b_next = SW'({a_reg + SW'(1), 1'b0});
                            state_next = S_RD;
                        end
                        else
                            state_next = S_ROOT;
                    end
                    else
                        state_next = S_FOLD;
                end
            end
            S_ROOT:
            begin
                cmd.root_rd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // result beat waiting
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= M_UP;
            cnt_reg   <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            best_reg  <= '0;
            root_reg  <= '0;
            st_reg    <= ST_OK;
            ch_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            best_reg  <= best_next;
            root_reg  <= root_next;
            st_reg    <= st_next;
            ch_reg    <= ch_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_WAIT);
    assign addr_a    = a_reg;
    assign addr_b    = b_reg;
    assign count     = cnt_reg;
    assign status    = st_reg;
endmodule

// File: src/kinetic_indexed_min_heap_core.sv
// Kinetic indexed min-heap: one result beat per input beat, one item at a time.
// Every item passes idle, decode, root read, result load and result wait around
// its operation. Insert climbs one level per compare and swap; advance rebuilds
// bottom-up, comparing each parent with its children and exchanging it downward;
// a query visits every parent-child pair and runs the bit-serial crossing divider
// on each, skipping the division for a pair with equal slopes.
module kinetic_indexed_min_heap_core #(
    parameter int CAPACITY = kih_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kih_pkg::kih_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output kih_pkg::kih_out_t out_data
);
    import kih_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);

    kih_cmd_t      cmd;
    kih_stat_t     stat;
    kih_in_t       held;
    logic [SW-1:0] addr_a, addr_b, count;
    logic [1:0]    status;

    kih_ctrl #(.CAPACITY(CAPACITY), .SW(SW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .held(held), .stat(stat),
        .cmd(cmd), .addr_a(addr_a), .addr_b(addr_b), .count(count), .status(status)
    );

    kih_datapath #(.CAPACITY(CAPACITY), .SW(SW)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .addr_a(addr_a),
        .addr_b(addr_b), .count(count), .status_in(status), .stat(stat),
        .out_item(out_data), .held(held)
    );
endmodule

// File: src/kih_checker.sv
`include "kinetic_indexed_min_heap_core_defines.svh"
module kih_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input kih_pkg::kih_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input kih_pkg::kih_out_t out_data
);
    import kih_pkg::*;

    // one item at a time: no new beat while a result is pending
    `KH_ASSERT_IMP(no_overlap, out_valid, !in_ready)
    // a result beat holds until taken
    `KH_ASSERT_NXT(out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // no event reported without a found flag
    `KH_ASSERT_IMP(no_event_time, out_valid && !out_data.event_found,
        out_data.event_time == NO_EVENT)
    // count never exceeds 1024, the default capacity
    `KH_ASSERT_IMP(count_cap, out_valid, out_data.entry_count <= 11'd1024)
endmodule

bind kinetic_indexed_min_heap_core kih_checker u_kih_checker (.*);
